### rtl/tea_variant_block_cipher_assert.svh
// Assertion macros for the TEA-variant block cipher.
`ifndef TEA_VARIANT_BLOCK_CIPHER_ASSERT_SVH
`define TEA_VARIANT_BLOCK_CIPHER_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent in this cycle implies consequent in the same cycle
`define TVBC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tvbc assertion failed");

// antecedent in this cycle implies consequent in the next cycle
`define TVBC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tvbc assertion failed");

`else

`define TVBC_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define TVBC_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/tvbc_pkg.sv
// Types, constants and round functions for the TEA-variant block cipher.
package tvbc_pkg;

  localparam int TVBC_ROUNDS = 32;

  localparam logic [31:0] RC_RESET      = 32'he09ffbb1;
  localparam logic [4:0]  SPECIAL_RESET = 5'd22;

  localparam int ADDR_W = 5;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_KEY0    = 3'd0;
  localparam logic [2:0] REG_KEY1    = 3'd1;
  localparam logic [2:0] REG_KEY2    = 3'd2;
  localparam logic [2:0] REG_KEY3    = 3'd3;
  localparam logic [2:0] REG_RC      = 3'd4;
  localparam logic [2:0] REG_SPECIAL = 3'd5;

  typedef struct packed {
    logic        operation;
    logic [31:0] block_first;
    logic [31:0] block_second;
  } tvbc_in_t;

  typedef struct packed {
    logic [31:0] result_first;
    logic [31:0] result_second;
  } tvbc_out_t;

  typedef struct packed {
    logic [31:0] key_word0;
    logic [31:0] key_word1;
    logic [31:0] key_word2;
    logic [31:0] key_word3;
    logic [31:0] round_constant;
  } tvbc_keys_t;

  // one block in flight; sum is the value the current round works with
  typedef struct packed {
    logic        op;
    logic [31:0] first;
    logic [31:0] second;
    logic [31:0] sum;
  } tvbc_stage_t;

  function automatic logic [31:0] mix_first(input logic [31:0] s, input logic [31:0] sum,
                                            input logic [31:0] k0, input logic [31:0] k1);
    return ((s << 4) + k0) ^ (s + sum) ^ ((s >> 5) + k1);
  endfunction

  function automatic logic [31:0] mix_second(input logic [31:0] f, input logic [31:0] sum,
                                             input logic [31:0] k2, input logic [31:0] k3,
                                             input logic sp);
    logic [31:0] lt;
    logic [31:0] rt;
    lt = sp ? (f << 2) : (f << 4);
    rt = sp ? (f >> 3) : (f >> 5);
    return (lt + k2) ^ (f + sum) ^ (rt + k3);
  endfunction

endpackage

### rtl/tvbc_round.sv
// One cipher round as two registered half-round stages, encrypt or decrypt per item.
module tvbc_round
  import tvbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  tvbc_stage_t in_stage,
  input  tvbc_keys_t  keys,
  input  logic        spec_enc,
  input  logic        spec_dec,
  output logic        out_valid,
  output tvbc_stage_t out_stage
);

  logic        mid_valid;
  tvbc_stage_t mid;
  tvbc_stage_t mid_next;
  tvbc_stage_t out_next;
  logic        sp_in;
  logic        sp_mid;
  logic [31:0] mix_a;
  logic [31:0] mix_b;

  assign sp_in  = in_stage.op ? spec_dec : spec_enc;
  assign sp_mid = mid.op ? spec_dec : spec_enc;

  // first half: encrypt updates the first word, decrypt undoes the second word
  always_comb begin
    mid_next = in_stage;
    if (in_stage.op) begin
      mix_a = mix_second(in_stage.first, in_stage.sum, keys.key_word2, keys.key_word3, sp_in);
      mid_next.second = in_stage.second - mix_a;
    end else begin
      mix_a = mix_first(in_stage.second, in_stage.sum, keys.key_word0, keys.key_word1);
      mid_next.first = in_stage.first + mix_a;
    end
  end

  // second half, plus the sum step toward the next round
  always_comb begin
    out_next = mid;
    if (mid.op) begin
      mix_b = mix_first(mid.second, mid.sum, keys.key_word0, keys.key_word1);
      out_next.first = mid.first - mix_b;
      out_next.sum   = mid.sum - keys.round_constant;
    end else begin
      mix_b = mix_second(mid.first, mid.sum, keys.key_word2, keys.key_word3, sp_mid);
      out_next.second = mid.second + mix_b;
      out_next.sum    = mid.sum + keys.round_constant;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    mid       <= mid_next;
    out_stage <= out_next;
  end

endmodule

### rtl/tea_variant_block_cipher.sv
// Top level of the TEA-variant block cipher: register file and unrolled round pipeline.
// From the accepting edge, a block passes the entry stage and then both half-round stages of each round before done.
// Throughput: one block per cycle; busy stays low, each round is two half-round stages.
// The decrypt start sum round_constant*ROUNDS is formed in the entry stage.
// Synchronous reset clears the pipeline valid bits and restores the register defaults.
// Results are shown for one cycle with done; the receiver cannot stall.
`include "tea_variant_block_cipher_assert.svh"

module tea_variant_block_cipher
  import tvbc_pkg::*;
#(
  parameter int ROUNDS = TVBC_ROUNDS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tvbc_in_t          block_in,
  output logic              done,
  output tvbc_out_t         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int LATENCY = 1 + 2 * ROUNDS;

  tvbc_keys_t  keys;
  logic [4:0]  special_round;
  logic        cfg_write;
  logic [2:0]  reg_idx;

  logic        vld [ROUNDS+1];
  tvbc_stage_t stg [ROUNDS+1];
  logic        entry_vld;
  tvbc_stage_t entry_stg;
  logic        accept;

  assign busy      = 1'b0;
  assign pready    = 1'b1;
  assign accept    = start && !busy;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys.key_word0      <= '0;
      keys.key_word1      <= '0;
      keys.key_word2      <= '0;
      keys.key_word3      <= '0;
      keys.round_constant <= RC_RESET;
      special_round       <= SPECIAL_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_KEY0:    keys.key_word0      <= pwdata;
        REG_KEY1:    keys.key_word1      <= pwdata;
        REG_KEY2:    keys.key_word2      <= pwdata;
        REG_KEY3:    keys.key_word3      <= pwdata;
        REG_RC:      keys.round_constant <= pwdata;
        REG_SPECIAL: special_round       <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KEY0:    prdata = keys.key_word0;
      REG_KEY1:    prdata = keys.key_word1;
      REG_KEY2:    prdata = keys.key_word2;
      REG_KEY3:    prdata = keys.key_word3;
      REG_RC:      prdata = keys.round_constant;
      REG_SPECIAL: prdata = {27'd0, special_round};
      default:     prdata = '0;
    endcase
  end

  // entry stage: encrypt enters with the round-0 sum already stepped
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= 1'b0;
    end else begin
      entry_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    entry_stg.op     <= block_in.operation;
    entry_stg.first  <= block_in.block_first;
    entry_stg.second <= block_in.block_second;
    entry_stg.sum    <= block_in.operation ? 32'(keys.round_constant * 32'(ROUNDS))
                                           : keys.round_constant;
  end

  assign vld[0] = entry_vld;
  assign stg[0] = entry_stg;

  for (genvar i = 0; i < ROUNDS; i++) begin : g_round
    logic spec_enc;
    logic spec_dec;
    assign spec_enc = (int'(special_round) == i);
    assign spec_dec = (int'(special_round) == ROUNDS - 1 - i);

    tvbc_round u_round (
      .clk      (clk),
      .rst      (rst),
      .in_valid (vld[i]),
      .in_stage (stg[i]),
      .keys     (keys),
      .spec_enc (spec_enc),
      .spec_dec (spec_dec),
      .out_valid(vld[i+1]),
      .out_stage(stg[i+1])
    );
  end

  assign done                 = vld[ROUNDS];
  assign result.result_first  = stg[ROUNDS].first;
  assign result.result_second = stg[ROUNDS].second;

  // every result traces back to an accepted transfer through the entry stage and all round stages
  `TVBC_ASSERT_SAME(a_done_latency, clk, rst, done, $past(accept && !rst, LATENCY))
  // special round register keeps the low five bits of the write
  `TVBC_ASSERT_NEXT(a_special_write, clk, rst, cfg_write && (reg_idx == REG_SPECIAL),
                    special_round == $past(pwdata[4:0]))
  // a transfer always shows up in the entry stage
  `TVBC_ASSERT_NEXT(a_entry_valid, clk, rst, accept, vld[0])

endmodule
